// File: rtl/ndfu_pkg.sv
// Shared types, constants and table values for the normal deviate generator.
package ndfu_pkg;

  localparam int SEGMENTS  = 32;
  localparam int SEG_BITS  = 5;
  localparam int OUT_W     = 20;
  localparam int OUT_FRAC  = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = 20'h7FFFF;
  localparam logic [63:0] DEC_UNIT = 64'd10000000000;

  // Table constants in units of 1e-10.
  localparam logic [63:0] TAB_A [SEGMENTS] = '{
    64'd0, 64'd391760900, 64'd784124100, 64'd1177700000, 64'd1573107000,
    64'd1970991000, 64'd2372021000, 64'd2776904000, 64'd3186394000, 64'd3601300000,
    64'd4022501000, 64'd4450965000, 64'd4887764000, 64'd5334097000, 64'd5791322000,
    64'd6260990000, 64'd6744898000, 64'd7245144000, 64'd7764218000, 64'd8305109000,
    64'd8871466000, 64'd9467818000, 64'd10099900000, 64'd10775160000,
    64'd11503490000, 64'd12298590000, 64'd13180110000, 64'd14177970000,
    64'd15341210000, 64'd16759400000, 64'd18627320000, 64'd21538750000};

  localparam logic [63:0] TAB_D [SEGMENTS-1] = '{
    64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd2636843000, 64'd2425085000, 64'd2255674000,
    64'd2116342000, 64'd1999243000, 64'd1899108000, 64'd1812252000, 64'd1736014000,
    64'd1668419000, 64'd1607967000, 64'd1553497000, 64'd1504094000, 64'd1459026000,
    64'd1417700000, 64'd1379632000, 64'd1344418000, 64'd1311722000, 64'd1281260000,
    64'd1252791000, 64'd1226109000, 64'd1201036000, 64'd1177417000, 64'd1155119000,
    64'd1134023000, 64'd1114027000, 64'd1095039000};

  localparam logic [63:0] TAB_T [SEGMENTS-1] = '{
    64'd7673828, 64'd23068700, 64'd38606180, 64'd54384540, 64'd70507000,
    64'd87083960, 64'd104235700, 64'd122095300, 64'd140812500, 64'd160557900,
    64'd181529000, 64'd203957300, 64'd228117700, 64'd254340700, 64'd283029600,
    64'd314682200, 64'd349923300, 64'd389548300, 64'd434587800, 64'd486403500,
    64'd546833400, 64'd618422200, 64'd704798300, 64'd811319500, 64'd946244400,
    64'd1123001000, 64'd1364980000, 64'd1716886000, 64'd2276241000,
    64'd3304980000, 64'd5847031000};

  localparam logic [63:0] TAB_H [SEGMENTS-1] = '{
    64'd392061700, 64'd393270500, 64'd395100000, 64'd397570300, 64'd400709300,
    64'd404553300, 64'd409148100, 64'd414550700, 64'd420831100, 64'd428074800,
    64'd436386300, 64'd445893200, 64'd456752300, 64'd469157100, 64'd483348700,
    64'd499629800, 64'd518385900, 64'd540113800, 64'd565465600, 64'd595313000,
    64'd630848900, 64'd673750300, 64'd726454400, 64'd792647100, 64'd878192200,
    64'd993039800, 64'd1155600000, 64'd1404344000, 64'd1836142000,
    64'd2790016000, 64'd7010474000};

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_FIRST    = 4'd2,
    OP_TAIL     = 4'd3,
    OP_TW_REM   = 4'd4,
    OP_TW_U     = 4'd5,
    OP_THRESH   = 4'd6,
    OP_CENTRE_W = 4'd7,
    OP_CU_W     = 4'd8,
    OP_THR_U    = 4'd9,
    OP_CAND_U   = 4'd10,
    OP_EMIT     = 4'd11
  } ndfu_op_e;

  typedef struct packed {
    ndfu_op_e op;
  } ndfu_cmd_t;

  typedef struct packed {
    logic tail_sel;
    logic tail_done;
    logic cand_le_t;
    logic cand_gt_thr;
    logic cand_ge_u;
    logic out_busy;
  } ndfu_sts_t;

  // Decimal constant to fixed point with f fractional bits, rounded to nearest.
  function automatic logic [63:0] to_fixed(input logic [63:0] v, input int f);
    logic [63:0] q;
    logic [63:0] r;
    q = v / DEC_UNIT;
    r = v % DEC_UNIT;
    return (q << f) + (((r << f) + (DEC_UNIT >> 1)) / DEC_UNIT);
  endfunction

endpackage

// File: rtl/normal_deviate_from_uniforms_top.sv
// Top level of the normal deviate generator (FL method, five-bit segment split).
//
// Each accepted word is one uniform u = x / 2^UNIFORM_BITS. After a word is
// accepted the sequencer works through its steps before it takes the next; the
// first word of a deviate that lands in the tail also walks the doubling loop
// one step a cycle. All products go through one shared multiplier in the
// datapath, one product per cycle, and the sequencer serialises the steps.
// A deviate appears on normal_value_o (signed, 16 fractional bits, saturated
// to plus or minus 8 - 2^-16) when the sampler accepts; words that lead to
// rejection produce no word on the output. The output register lets a new
// sample be taken while a result still waits; a word that completes a further
// deviate holds the input until the waiting result has been taken, stalling
// for as long as normal_value_ready_i stays low.
module normal_deviate_from_uniforms_top import ndfu_pkg::*; #(
  parameter int UNIFORM_BITS        = 32,
  parameter int TABLE_FRACTION_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             uniform_sample_i,
  input  logic                    uniform_sample_valid_i,
  output logic                    uniform_sample_ready_o,
  output logic signed [OUT_W-1:0] normal_value_o,
  output logic                    normal_value_valid_o,
  input  logic                    normal_value_ready_i
);

  ndfu_cmd_t        cmd;
  ndfu_sts_t        sts;
  logic [OUT_W-1:0] out_data;

  ndfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (uniform_sample_valid_i),
    .in_ready_o (uniform_sample_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Only the low UNIFORM_BITS of the word take part.
  ndfu_datapath #(
    .UNIFORM_BITS        (UNIFORM_BITS),
    .TABLE_FRACTION_BITS (TABLE_FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (uniform_sample_i[UNIFORM_BITS-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (normal_value_ready_i),
    .out_valid_o (normal_value_valid_o),
    .out_data_o  (out_data)
  );

  assign normal_value_o = signed'(out_data);

endmodule

// File: rtl/ndfu_ctrl.sv
// Sequencer for the normal deviate generator: phase tracking and datapath commands.
module ndfu_ctrl import ndfu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output ndfu_cmd_t cmd_o,
  input  ndfu_sts_t sts_i
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DISP   = 10'b0000000010,
    ST_FCHK   = 10'b0000000100,
    ST_CTEST  = 10'b0000001000,
    ST_TAIL   = 10'b0000010000,
    ST_TW     = 10'b0000100000,
    ST_TTHR   = 10'b0001000000,
    ST_CUTHR  = 10'b0010000000,
    ST_CHK    = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_e;

  typedef enum logic [7:0] {
    PH_START   = 8'b00000001,
    PH_C_U     = 8'b00000010,
    PH_C_CMP   = 8'b00000100,
    PH_C_USTAR = 8'b00001000,
    PH_C_RST   = 8'b00010000,
    PH_T_USTAR = 8'b00100000,
    PH_T_CMP   = 8'b01000000,
    PH_T_RST   = 8'b10000000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        state_d = ST_IDLE;
        case (phase_q)
          PH_C_U: begin
            cmd_o.op = OP_CU_W;
            state_d  = ST_CUTHR;
          end
          PH_C_CMP: begin
            if (sts_i.cand_ge_u) begin
              cmd_o.op = OP_THR_U;
              phase_d  = PH_C_USTAR;
            end else begin
              phase_d = PH_C_RST;
            end
          end
          PH_T_CMP: begin
            if (sts_i.cand_ge_u) begin
              cmd_o.op = OP_THR_U;
              phase_d  = PH_T_USTAR;
            end else begin
              phase_d = PH_T_RST;
            end
          end
          PH_C_USTAR, PH_T_USTAR: begin
            cmd_o.op = OP_CAND_U;
            state_d  = ST_CHK;
          end
          PH_C_RST: begin
            cmd_o.op = OP_CAND_U;
            state_d  = ST_CTEST;
          end
          PH_T_RST: begin
            cmd_o.op = OP_TW_U;
            state_d  = ST_TTHR;
          end
          default: begin
            cmd_o.op = OP_FIRST;
            state_d  = ST_FCHK;
          end
        endcase
      end
      ST_FCHK: begin
        state_d = sts_i.tail_sel ? ST_TAIL : ST_CTEST;
      end
      ST_CTEST: begin
        if (sts_i.cand_le_t) begin
          phase_d = PH_C_U;
          state_d = ST_IDLE;
        end else begin
          cmd_o.op = OP_CENTRE_W;
          state_d  = ST_EMIT;
        end
      end
      ST_TAIL: begin
        cmd_o.op = OP_TAIL;
        if (sts_i.tail_done) begin
          state_d = ST_TW;
        end
      end
      ST_TW: begin
        cmd_o.op = OP_TW_REM;
        state_d  = ST_TTHR;
      end
      ST_TTHR: begin
        cmd_o.op = OP_THRESH;
        phase_d  = PH_T_USTAR;
        state_d  = ST_IDLE;
      end
      ST_CUTHR: begin
        cmd_o.op = OP_THRESH;
        phase_d  = PH_C_USTAR;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.cand_gt_thr) begin
          state_d = ST_EMIT;
        end else begin
          phase_d = (phase_q == PH_T_USTAR) ? PH_T_CMP : PH_C_CMP;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          phase_d  = PH_START;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        phase_d = PH_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_START;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// File: rtl/ndfu_datapath.sv
// Datapath of the normal deviate generator: tables, shared multiplier and state registers.
module ndfu_datapath import ndfu_pkg::*; #(
  parameter int UNIFORM_BITS        = 32,
  parameter int TABLE_FRACTION_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [UNIFORM_BITS-1:0] sample_i,
  input  ndfu_cmd_t               cmd_i,
  output ndfu_sts_t               sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [OUT_W-1:0]        out_data_o
);

  localparam int F    = TABLE_FRACTION_BITS;
  localparam int UB   = UNIFORM_BITS;
  localparam int BW   = F + 4;
  localparam int VW   = F + 2;
  localparam int LOW  = UB - SEG_BITS;
  localparam int RW   = LOW + 1;
  localparam int MAW  = BW + 1;
  localparam int PW   = MAW + VW;
  localparam int XR   = (UB >= F) ? UB - F : 0;
  localparam int XL   = (UB >= F) ? 0 : F - UB;
  localparam int RR   = (LOW >= F) ? LOW - F : 0;
  localparam int RL   = (LOW >= F) ? 0 : F - LOW;
  localparam int SHW  = UB + F + 2;
  localparam int OSH  = F - OUT_FRAC;
  localparam logic [SEG_BITS-1:0] SEG_LAST  = SEG_BITS'(SEGMENTS - 1);
  localparam logic [SEG_BITS-1:0] SHORT_MAX = SEG_BITS'(SEGMENTS - 2);
  localparam logic [SEG_BITS-1:0] TAIL_START = SEG_BITS'(6);

  logic [BW-1:0] a_fix [SEGMENTS];
  logic [VW-1:0] d_fix [SEGMENTS-1];
  logic [VW-1:0] t_fix [SEGMENTS-1];
  logic [VW-1:0] h_fix [SEGMENTS-1];

  for (genvar g = 0; g < SEGMENTS; g++) begin : g_tab_a
    assign a_fix[g] = BW'(to_fixed(TAB_A[g], F));
  end
  for (genvar g = 0; g < SEGMENTS - 1; g++) begin : g_tab_s
    assign d_fix[g] = VW'(to_fixed(TAB_D[g], F));
    assign t_fix[g] = VW'(to_fixed(TAB_T[g], F));
    assign h_fix[g] = VW'(to_fixed(TAB_H[g], F));
  end

  logic [UB-1:0]       x_q;
  logic                neg_q;
  logic [SEG_BITS-1:0] seg_q;
  logic [BW-1:0]       base_q;
  logic [VW-1:0]       cand_q, thr_q, work_q;
  logic [RW-1:0]       rem_q;
  logic                tail_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_q;

  // Uniform as a fraction with F bits.
  logic [SHW-1:0] x_ext, r_ext;
  logic [VW-1:0]  uf, rem_f;
  always_comb begin
    x_ext = SHW'(x_q);
    x_ext = (x_ext >> XR) << XL;
    uf    = VW'(x_ext);
    r_ext = SHW'(rem_q);
    r_ext = (r_ext >> RR) << RL;
    rem_f = VW'(r_ext);
  end

  // First word: sign, segment and remainder.
  logic               f_neg;
  logic [UB:0]        f_w;
  logic [SEG_BITS:0]  f_seg_raw;
  logic [SEG_BITS-1:0] f_seg;
  logic [RW-1:0]      f_rem;
  logic [SHW-1:0]     f_ext;
  logic [VW-1:0]      f_cand;
  always_comb begin
    f_neg     = x_q > {1'b1, {(UB-1){1'b0}}};
    f_w       = {x_q, 1'b0} - (f_neg ? {1'b1, {UB{1'b0}}} : '0);
    f_seg_raw = f_w[UB:LOW];
    if (f_seg_raw[SEG_BITS]) begin
      f_seg = SEG_LAST;
      f_rem = {1'b1, {LOW{1'b0}}};
    end else begin
      f_seg = f_seg_raw[SEG_BITS-1:0];
      f_rem = {1'b0, f_w[LOW-1:0]};
    end
    f_ext  = (SHW'(f_rem) >> RR) << RL;
    f_cand = VW'(f_ext);
  end

  // Table lookups for the current segment.
  logic [SEG_BITS-1:0] segm1, sidx;
  logic [VW-1:0]       d_sel, t_sel, h_sel;
  logic [BW-1:0]       a_next;
  always_comb begin
    segm1  = seg_q - 1'b1;
    sidx   = (segm1 > SHORT_MAX) ? SHORT_MAX : segm1;
    d_sel  = d_fix[sidx];
    t_sel  = t_fix[sidx];
    h_sel  = h_fix[sidx];
    a_next = a_fix[seg_q];
  end

  // Tail doubling step.
  logic [RW:0]   rem2;
  logic          rem_ge;
  logic          tail_done;
  logic [RW-1:0] rem_nx;
  always_comb begin
    rem2      = {rem_q, 1'b0};
    rem_ge    = rem2 >= (RW+1)'({1'b1, {LOW{1'b0}}});
    tail_done = rem_ge || (seg_q >= SEG_LAST);
    rem_nx    = rem_ge ? RW'(rem2 - (RW+1)'({1'b1, {LOW{1'b0}}})) : RW'(rem2);
  end

  // Shared multiplier.
  logic [MAW-1:0] ma;
  logic [VW-1:0]  mb;
  logic [PW-1:0]  prod;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_TW_REM: begin
        ma = MAW'(rem_f);
        mb = d_sel;
      end
      OP_TW_U: begin
        ma = MAW'(uf);
        mb = d_sel;
      end
      OP_CENTRE_W: begin
        ma = MAW'(cand_q - t_sel);
        mb = h_sel;
      end
      OP_CU_W: begin
        ma = MAW'(a_next - base_q);
        mb = uf;
      end
      OP_THRESH: begin
        ma = MAW'(work_q) + {base_q, 1'b0};
        mb = work_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = PW'(ma) * PW'(mb);
  end

  // Result formatting.
  logic [BW:0]      y;
  logic [BW:0]      m_full;
  logic [OUT_W-1:0] m_sat;
  logic [OUT_W-1:0] out_val;
  always_comb begin
    y      = (BW+1)'(base_q) + (BW+1)'(work_q);
    m_full = y >> OSH;
    m_sat  = (m_full > (BW+1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(m_full);
    out_val = neg_q ? OUT_W'(-m_sat) : m_sat;
  end

  // Hold the payload registers and update them per command.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: x_q <= sample_i;
      OP_FIRST: begin
        neg_q <= f_neg;
        if (f_seg != '0) begin
          seg_q  <= f_seg;
          base_q <= a_fix[f_seg - 1'b1];
          cand_q <= f_cand;
        end else begin
          seg_q  <= TAIL_START;
          base_q <= a_fix[SEGMENTS-1];
          rem_q  <= f_rem;
        end
      end
      OP_TAIL: begin
        rem_q <= rem_nx;
        if (!tail_done) begin
          base_q <= base_q + BW'(d_sel);
          seg_q  <= seg_q + 1'b1;
        end
      end
      OP_TW_REM, OP_TW_U, OP_CENTRE_W, OP_CU_W: work_q <= VW'(prod >> F);
      OP_THRESH: thr_q  <= VW'(prod >> (F + 1));
      OP_THR_U:  thr_q  <= uf;
      OP_CAND_U: cand_q <= uf;
      OP_EMIT:   out_q  <= out_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FIRST) begin
        tail_q <= (f_seg == '0);
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.tail_sel    = tail_q;
  assign sts_o.tail_done   = tail_done;
  assign sts_o.cand_le_t   = cand_q <= t_sel;
  assign sts_o.cand_gt_thr = cand_q > thr_q;
  assign sts_o.cand_ge_u   = cand_q >= uf;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
